FILE: rtl/msbr_pkg.sv
`timescale 1ns / 1ps

package msbr_pkg;

  // default sizes
  localparam int unsigned BUF_BYTES     = 4096;
  localparam int unsigned MAX_READ_BITS = 32;

  // end position in bits: a 13-bit byte count times eight
  localparam int unsigned END_W = 16;

  // command codes
  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_BIND  = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_ALIGN = 3'd3;
  localparam logic [2:0] CMD_SEEK  = 3'd4;

  // seek origins
  localparam logic [1:0] ORG_BEGIN = 2'd0;
  localparam logic [1:0] ORG_CUR   = 2'd1;
  localparam logic [1:0] ORG_END   = 2'd2;

  // clears the low three cursor bits on align
  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFF8;

  typedef struct packed {
    logic [2:0]         command;
    logic [11:0]        byte_address;
    logic [7:0]         byte_value;
    logic [12:0]        byte_count;
    logic [5:0]         bit_count;
    logic signed [31:0] seek_offset;
    logic [1:0]         seek_origin;
  } in_req_t;

  typedef struct packed {
    logic               status;
    logic [31:0]        read_value;
    logic signed [31:0] bit_position;
    logic               at_end;
    logic               overrun;
  } out_req_t;

endpackage

FILE: rtl/msbr_ram.sv
`timescale 1ns / 1ps

module msbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/msb_first_bit_reader.sv
// a request is registered in the fetch stage while the banks read, then commits into
// the output register; no new request is taken while one waits in the fetch stage for
// the buffer read and the commit that follows (merge, write back, state update)
// a stalled output holds the next request in the fetch stage until the result is taken
// reset: cursor, end position and overrun clear at once; buffer bytes stay undefined
`timescale 1ns / 1ps

module msb_first_bit_reader #(
  parameter int unsigned BUF_BYTES     = msbr_pkg::BUF_BYTES,
  parameter int unsigned MAX_READ_BITS = msbr_pkg::MAX_READ_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  msbr_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msbr_pkg::out_req_t out_req_o
);

  // buffer is kept as 32-bit words, byte lane 0 in the top bits so that two
  // consecutive words read as one msb-first stream; even and odd words sit in
  // separate banks, so any 32-bit window (at most five bytes) is one fetch
  localparam int unsigned WORDS      = (BUF_BYTES + 3) / 4;
  localparam int unsigned BANK_DEPTH = (WORDS + 1) / 2;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
  localparam int unsigned LA_W       = BANK_AW + 3;

  // fetch stage: request waits here while the banks return data
  logic              valid_a_q;
  msbr_pkg::in_req_t req_q;

  // architectural state
  logic [31:0]                 cursor_q, cursor_d;
  logic [msbr_pkg::END_W-1:0]  end_q, end_d;
  logic                        ovr_q, ovr_d;

  // output register
  logic               out_valid_q;
  msbr_pkg::out_req_t out_q, out_d;

  logic acc;
  logic commit;

  // bank ports
  logic [BANK_AW-1:0] rd_even_addr, rd_odd_addr, wr_addr;
  logic [31:0]        rd_even, rd_odd, wr_data;
  logic               we_even, we_odd;

  // read address generation from the incoming request
  logic [LA_W-1:0]    in_load_ext;
  logic [BANK_AW:0]   cur_word, cur_word_inc;

  // commit stage signals
  logic [LA_W-1:0] q_load_ext;
  logic [1:0]      lane;
  logic [31:0]     bank_word;
  logic [31:0]     merged;
  logic            load_in_range;
  logic [31:0]     cnt_ext, cnt_sat;
  logic [31:0]     word0, word1;
  logic [63:0]     window, shifted;
  logic [31:0]     top_bits, fetched;
  logic            too_wide, past_end;
  logic [31:0]     status_val;
  logic            status;
  logic [31:0]     value;

  // one request at a time: the fetch stage interlocks the next read against
  // the write back of a load and against the cursor update
  assign in_stall_o = valid_a_q;
  assign acc        = in_valid_i & ~in_stall_o;
  assign commit     = valid_a_q & (~out_valid_q | ~out_stall_i);

  // bank read addresses
  assign in_load_ext  = LA_W'(in_req_i.byte_address);
  assign cur_word     = cursor_q[BANK_AW+5:5];
  assign cur_word_inc = cur_word + {{BANK_AW{1'b0}}, 1'b1};

  always_comb begin
    if (in_req_i.command == msbr_pkg::CMD_LOAD) begin
      // both banks read the load's row; the commit picks the bank
      rd_even_addr = in_load_ext[LA_W-1:3];
      rd_odd_addr  = in_load_ext[LA_W-1:3];
    end else begin
      // window starts at word cur_word, the next word lives in the other bank
      rd_even_addr = cur_word_inc[BANK_AW:1];
      rd_odd_addr  = cur_word[BANK_AW:1];
    end
  end

  msbr_ram #(
    .WIDTH (32),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (acc),
    .raddr_i (rd_even_addr),
    .rdata_o (rd_even)
  );

  msbr_ram #(
    .WIDTH (32),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (acc),
    .raddr_i (rd_odd_addr),
    .rdata_o (rd_odd)
  );

  // load: read-modify-write of one byte lane
  assign q_load_ext    = LA_W'(req_q.byte_address);
  assign lane          = req_q.byte_address[1:0];
  assign bank_word     = req_q.byte_address[2] ? rd_odd : rd_even;
  assign load_in_range = 32'(req_q.byte_address) < 32'(BUF_BYTES);
  assign wr_addr       = q_load_ext[LA_W-1:3];
  assign wr_data       = merged;

  always_comb begin
    merged = bank_word;
    // lane 0 sits in the top byte
    merged[{~lane, 3'b000} +: 8] = req_q.byte_value;
  end

  // bind: byte count saturates at the buffer size
  assign cnt_ext = 32'(req_q.byte_count);
  assign cnt_sat = (cnt_ext > 32'(BUF_BYTES)) ? 32'(BUF_BYTES) : cnt_ext;

  // read: the two fetched words form a 64-bit msb-first window
  assign word0    = cursor_q[5] ? rd_odd : rd_even;
  assign word1    = cursor_q[5] ? rd_even : rd_odd;
  assign window   = {word0, word1};
  assign shifted  = window << cursor_q[4:0];
  assign top_bits = shifted[63:32];
  // a zero-bit read shifts everything out
  assign fetched  = top_bits >> (6'd32 - req_q.bit_count);

  assign too_wide = req_q.bit_count > 6'(MAX_READ_BITS);
  // negative cursor, or the unsigned end of the read beyond the end position
  assign past_end = cursor_q[31] |
                    (({1'b0, cursor_q} + 33'(req_q.bit_count)) > 33'(end_q));

  always_comb begin
    cursor_d   = cursor_q;
    end_d      = end_q;
    ovr_d      = ovr_q;
    status     = 1'b0;
    value      = '0;
    we_even    = 1'b0;
    we_odd     = 1'b0;
    status_val = '0;
    case (req_q.command)
      msbr_pkg::CMD_LOAD: begin
        // address beyond the buffer is dropped silently
        if (commit && load_in_range) begin
          we_even = ~req_q.byte_address[2];
          we_odd  = req_q.byte_address[2];
        end
      end
      msbr_pkg::CMD_BIND: begin
        end_d    = {cnt_sat[12:0], 3'b000};
        cursor_d = '0;
        ovr_d    = 1'b0;
      end
      msbr_pkg::CMD_READ: begin
        if (too_wide) begin
          status = 1'b1;
        end else if (past_end) begin
          ovr_d  = 1'b1;
          status = 1'b1;
        end else begin
          value    = fetched;
          cursor_d = cursor_q + 32'(req_q.bit_count);
        end
      end
      msbr_pkg::CMD_ALIGN: begin
        cursor_d = (cursor_q + 32'd7) & msbr_pkg::ALIGN_MASK;
      end
      msbr_pkg::CMD_SEEK: begin
        case (req_q.seek_origin)
          msbr_pkg::ORG_BEGIN: cursor_d = $unsigned(req_q.seek_offset);
          msbr_pkg::ORG_CUR:   cursor_d = cursor_q + $unsigned(req_q.seek_offset);
          msbr_pkg::ORG_END:   cursor_d = 32'(end_q) + $unsigned(req_q.seek_offset);
          default:             status = 1'b1;
        endcase
      end
      default: begin
        // unknown command
        status = 1'b1;
      end
    endcase
    status_val[0] = status;

    out_d.status       = status_val[0];
    out_d.read_value   = value;
    out_d.bit_position = $signed(cursor_d);
    // end flag uses an unsigned compare
    out_d.at_end       = cursor_d >= 32'(end_q == end_d ? end_q : end_d);
    out_d.overrun      = ovr_d;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cursor_q    <= '0;
      end_q       <= '0;
      ovr_q       <= 1'b0;
    end else begin
      if (acc) begin
        valid_a_q <= 1'b1;
      end else if (commit) begin
        valid_a_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        cursor_q    <= cursor_d;
        end_q       <= end_d;
        ovr_q       <= ovr_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q <= in_req_i;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // only a committed load in range writes, and into one bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_even || we_odd) |->
      (commit && req_q.command == msbr_pkg::CMD_LOAD && !(we_even && we_odd)))
    else $error("bank write outside a committed load");

  // every commit presents a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("committed request produced no result");

  // cursor only moves on a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(cursor_q))
    else $error("cursor changed without a commit");

  // overrun is set only by a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && !ovr_q && ovr_d) |-> (req_q.command == msbr_pkg::CMD_READ))
    else $error("overrun set by a command other than read");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // command codes the block does not define, and the seek origin it rejects
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [1:0] ORG_BAD       = 2'd3;

  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT = 4000;  // cycles without any handshake
  localparam int unsigned SETTLE      = 8;     // cycles past the last result

  // expected-result store plus a bit-exact copy of the reader state
  class bitstream_scoreboard;
    logic [7:0]         store [msbr_pkg::BUF_BYTES];
    bit                 written [msbr_pkg::BUF_BYTES];
    logic [31:0]        cursor;
    logic [15:0]        end_pos;
    logic               ovr;
    msbr_pkg::out_req_t expected_results [$];
    int                 errors;

    function new();
      cursor  = '0;
      end_pos = '0;
      ovr     = 1'b0;
      errors  = 0;
    endfunction

    // advance the state by one request and return its result
    function msbr_pkg::out_req_t apply_command(msbr_pkg::in_req_t r);
      msbr_pkg::out_req_t res;
      longint             c;
      int unsigned        cnt;
      int unsigned        i;
      logic [31:0]        pos;
      res = '0;
      case (r.command)
        msbr_pkg::CMD_LOAD: begin
          store[r.byte_address]   = r.byte_value;
          written[r.byte_address] = 1'b1;
        end
        msbr_pkg::CMD_BIND: begin
          cnt     = (r.byte_count > msbr_pkg::BUF_BYTES) ? msbr_pkg::BUF_BYTES
                                                         : r.byte_count;
          end_pos = 16'(cnt * 8);
          cursor  = '0;
          ovr     = 1'b0;
        end
        msbr_pkg::CMD_READ: begin
          c = longint'($signed(cursor));
          if (r.bit_count > msbr_pkg::MAX_READ_BITS) begin
            res.status = 1'b1;
          end else if (c < 0 || c + longint'(r.bit_count) > longint'(end_pos)) begin
            ovr        = 1'b1;
            res.status = 1'b1;
          end else begin
            for (i = 0; i < r.bit_count; i++) begin
              pos = cursor + i;
              res.read_value = {res.read_value[30:0], store[pos >> 3][3'd7 - pos[2:0]]};
            end
            cursor = cursor + r.bit_count;
          end
        end
        msbr_pkg::CMD_ALIGN: cursor = (cursor + 32'd7) & msbr_pkg::ALIGN_MASK;
        msbr_pkg::CMD_SEEK: begin
          case (r.seek_origin)
            msbr_pkg::ORG_BEGIN: cursor = r.seek_offset;
            msbr_pkg::ORG_CUR:   cursor = cursor + r.seek_offset;
            msbr_pkg::ORG_END:   cursor = {16'h0, end_pos} + r.seek_offset;
            default:             res.status = 1'b1;
          endcase
        end
        default: res.status = 1'b1;
      endcase
      res.bit_position = cursor;
      res.at_end       = (cursor >= {16'h0, end_pos});
      res.overrun      = ovr;
      return res;
    endfunction

    // first byte a successful read would touch that was never loaded, else -1
    function int missing_byte(msbr_pkg::in_req_t r);
      longint      c;
      int unsigned first;
      int unsigned last;
      int unsigned b;
      c = longint'($signed(cursor));
      if (r.command != msbr_pkg::CMD_READ || r.bit_count == 0 ||
          r.bit_count > msbr_pkg::MAX_READ_BITS ||
          c < 0 || c + longint'(r.bit_count) > longint'(end_pos))
        return -1;
      first = cursor >> 3;
      last  = (cursor + r.bit_count - 1) >> 3;
      for (b = first; b <= last; b++)
        if (!written[b]) return int'(b);
      return -1;
    endfunction

    function void note_request(msbr_pkg::in_req_t r);
      expected_results.push_back(apply_command(r));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(msbr_pkg::out_req_t got);
      msbr_pkg::out_req_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, got %0h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("bit_position", want.bit_position, got.bit_position);
      compare_field("at_end", 32'(want.at_end), 32'(got.at_end));
      compare_field("overrun", 32'(want.overrun), 32'(got.overrun));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_r = 1'b0;
  msbr_pkg::in_req_t  in_req_r = '0;
  logic               out_stall_r = 1'b0;
  logic               in_stall;
  logic               out_valid;
  msbr_pkg::out_req_t out_req;

  bitstream_scoreboard sb = new();

  int unsigned sent = 0;
  int unsigned send_pct = 0;   // chance in a hundred that the sender idles a cycle
  int unsigned recv_pct = 0;   // chance in a hundred that the receiver stalls a cycle
  logic        hold_tgl = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned quiet = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  msb_first_bit_reader u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_r),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req_r),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall_r),
    .out_req_o   (out_req)
  );

  // receiver: random stalls, plus a long hold-off whenever the toggle flips
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        out_stall_r <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_r <= ($urandom_range(99) < recv_pct);
    end
  end

  // result check and no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall_r) sb.check_result(out_req);
    if ((in_valid_r && !in_stall) || (out_valid && !out_stall_r)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // request with random background in the fields the command ignores
  function automatic msbr_pkg::in_req_t cmd_req(logic [2:0] c);
    logic [95:0]       raw;
    msbr_pkg::in_req_t r;
    raw = {$urandom(), $urandom(), $urandom()};
    r = raw[$bits(msbr_pkg::in_req_t)-1:0];
    r.command = c;
    return r;
  endfunction

  function automatic msbr_pkg::in_req_t load_req(logic [11:0] a, logic [7:0] v);
    msbr_pkg::in_req_t r;
    r = cmd_req(msbr_pkg::CMD_LOAD);
    r.byte_address = a;
    r.byte_value   = v;
    return r;
  endfunction

  function automatic msbr_pkg::in_req_t bind_req(logic [12:0] n);
    msbr_pkg::in_req_t r;
    r = cmd_req(msbr_pkg::CMD_BIND);
    r.byte_count = n;
    return r;
  endfunction

  function automatic msbr_pkg::in_req_t read_req(logic [5:0] n);
    msbr_pkg::in_req_t r;
    r = cmd_req(msbr_pkg::CMD_READ);
    r.bit_count = n;
    return r;
  endfunction

  function automatic msbr_pkg::in_req_t seek_req(logic [1:0] org, logic signed [31:0] off);
    msbr_pkg::in_req_t r;
    r = cmd_req(msbr_pkg::CMD_SEEK);
    r.seek_origin = org;
    r.seek_offset = off;
    return r;
  endfunction

  // one request: optional idle gap, then hold valid until it is taken
  task automatic push_request(input msbr_pkg::in_req_t r);
    while ($urandom_range(99) < send_pct) begin
      in_valid_r <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_r <= 1'b1;
    in_req_r   <= r;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(r);
    sent++;
  endtask

  // a read that would touch never-loaded bytes gets those bytes loaded first
  task automatic issue_command(input msbr_pkg::in_req_t r);
    int miss;
    miss = sb.missing_byte(r);
    while (miss >= 0) begin
      push_request(load_req(12'(miss), 8'($urandom)));
      miss = sb.missing_byte(r);
    end
    push_request(r);
  endtask

  // one operation inside a bound stream of nbytes bytes
  function automatic msbr_pkg::in_req_t stream_op(int unsigned nbytes);
    int unsigned k;
    int          span;
    k    = $urandom_range(99);
    span = int'(nbytes) * 8;
    if (k < 55) begin
      return read_req(($urandom_range(19) == 0) ? 6'($urandom_range(33, 63))
                                                : 6'($urandom_range(0, 32)));
    end else if (k < 65) begin
      return cmd_req(msbr_pkg::CMD_ALIGN);
    end else if (k < 85) begin
      case ($urandom_range(19))
        0:       return seek_req(ORG_BAD, $urandom());
        1:       return seek_req(2'($urandom_range(0, 2)), $urandom());
        2, 3, 4, 5, 6:
                 return seek_req(msbr_pkg::ORG_BEGIN, $urandom_range(0, span + 8));
        7, 8, 9, 10, 11, 12:
                 return seek_req(msbr_pkg::ORG_CUR, int'($urandom_range(0, 48)) - 24);
        default: return seek_req(msbr_pkg::ORG_END, -int'($urandom_range(0, span + 8)));
      endcase
    end else if (k < 90) begin
      return cmd_req(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
    end
    return load_req(12'($urandom), 8'($urandom));
  endfunction

  // well-formed stream: fill the buffer head, bind it, then work through it
  task automatic run_stream();
    int unsigned nbytes;
    int unsigned ops;
    int unsigned i;
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(17, 160) : $urandom_range(1, 16);
    for (i = 0; i < nbytes; i++) issue_command(load_req(12'(i), 8'($urandom)));
    issue_command(bind_req(13'(nbytes)));
    ops = $urandom_range(6, 24);
    for (i = 0; i < ops; i++) issue_command(stream_op(nbytes));
  endtask

  // fully random requests, any command code and any field value
  task automatic run_noise();
    int unsigned i;
    for (i = 0; i < 5; i++) issue_command(cmd_req(3'($urandom_range(0, 7))));
  endtask

  // pause the sender until every outstanding result has come back
  task automatic drain();
    in_valid_r <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty buffer, bit order, width limit, overrun, bad codes, wrap
    issue_command(read_req(6'd0));
    issue_command(read_req(6'd1));
    issue_command(load_req(12'd0, 8'hA5));
    issue_command(load_req(12'd1, 8'hFF));
    issue_command(load_req(12'd2, 8'h00));
    issue_command(load_req(12'd3, 8'h3C));
    issue_command(load_req(12'd4, 8'h81));
    issue_command(load_req(12'd4092, 8'h80));
    issue_command(load_req(12'd4093, 8'h01));
    issue_command(load_req(12'd4094, 8'h5A));
    issue_command(load_req(12'd4095, 8'hFF));
    issue_command(bind_req(13'd5));
    issue_command(read_req(6'd33));
    issue_command(read_req(6'd3));
    issue_command(cmd_req(msbr_pkg::CMD_ALIGN));
    issue_command(read_req(6'd32));
    issue_command(read_req(6'd1));
    issue_command(seek_req(ORG_BAD, 32'sd0));
    issue_command(cmd_req(CMD_UNUSED_HI));
    // oversized count saturates; read the last word of the buffer
    issue_command(bind_req(13'h1FFF));
    issue_command(seek_req(msbr_pkg::ORG_END, -32'sd32));
    issue_command(read_req(6'd32));
    issue_command(seek_req(msbr_pkg::ORG_CUR, 32'sh8000_0000));
    issue_command(read_req(6'd0));
    issue_command(seek_req(msbr_pkg::ORG_BEGIN, 32'shFFFF_FFFD));
    issue_command(cmd_req(msbr_pkg::CMD_ALIGN));
    issue_command(bind_req(13'd0));
    drain();

    // random: no idling, sender idle, receiver stalling, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 81; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 81; end
        default: begin send_pct = 26; recv_pct = 26; end
      endcase
      // the receiver holds off while requests keep coming, so the block backs up
      if (phase == 0) hold_tgl <= ~hold_tgl;
      phase_end = sent + ITEM_TARGET / 4;
      while (sent < phase_end) begin
        if ($urandom_range(7) == 0) run_noise();
        else run_stream();
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/msbr_pkg.sv
rtl/msbr_ram.sv
rtl/msb_first_bit_reader.sv
tb/tb_top.sv
